FILE: sv/sorted_set_insert_remove_min_core_macros.svh
// ----------------------------------------------------------------------------
// sorted set core assertion macros
// shared concurrent check templates for the sorted set core
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_REMOVE_MIN_CORE_MACROS_SVH
`define SORTED_SET_INSERT_REMOVE_MIN_CORE_MACROS_SVH

// same-cycle implication check
`define SSIRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssirm: same-cycle check failed");

// next-cycle implication check
`define SSIRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssirm: next-cycle check failed");

`endif

FILE: sv/ssirm_pkg.sv
// ----------------------------------------------------------------------------
// ssirm_pkg
// types, constants and codes shared by the sorted set core
// ----------------------------------------------------------------------------
package ssirm_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 7;

    // request kinds
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // broadcast control to every cell
    typedef struct packed {
        logic              cmp;
        logic              ins;
        logic              rem;
        logic [DATA_W-1:0] value;
    } t_ctl;

    // what a cell hands to its right-hand neighbour
    typedef struct packed {
        logic [DATA_W-1:0] entry;
        logic              occ;
        logic              gt;
    } t_link;

endpackage

FILE: sv/ssirm_req_if.sv
// ----------------------------------------------------------------------------
// ssirm_req_if
// request channel: valid/ready with opcode and value
// ----------------------------------------------------------------------------
interface ssirm_req_if;
    import ssirm_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);

endinterface

FILE: sv/ssirm_res_if.sv
// ----------------------------------------------------------------------------
// ssirm_res_if
// result channel: valid/ready with smallest value, count and status
// ----------------------------------------------------------------------------
interface ssirm_res_if;
    import ssirm_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  smallest;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;

    modport source (output valid, output smallest, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input smallest, input entry_count, input status,
                    output ready);

endinterface

FILE: sv/ssirm_cell.sv
// ----------------------------------------------------------------------------
// ssirm_cell
// one slot of the sorted chain: holds an entry, compares it with the
// broadcast value and shifts in from its left neighbour on insert
// ----------------------------------------------------------------------------
module ssirm_cell import ssirm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  t_link             i_left,
    input  logic              i_right_occ,
    output t_link             o_link,
    output logic              o_eq,
    output logic [DATA_W-1:0] o_tail
);

    logic [DATA_W-1:0] r_entry;
    logic              r_occ;
    logic              r_gt;
    logic              r_eq;

    // occupancy stays a contiguous prefix of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.ins) begin
            r_occ <= r_occ | i_left.occ;
        end else if (i_ctl.rem) begin
            r_occ <= r_occ & i_right_occ;
        end
    end

    // compare against the request, then keep, take the value or shift in
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_gt <= r_occ && ($signed(r_entry) > $signed(i_ctl.value));
            r_eq <= r_occ && (r_entry == i_ctl.value);
        end
        if (i_ctl.ins && !r_gt) begin
            r_entry <= i_left.gt ? i_ctl.value : i_left.entry;
        end
    end

    assign o_link.entry = r_entry;
    assign o_link.occ   = r_occ;
    assign o_link.gt    = r_gt;
    assign o_eq         = r_eq;

    // last occupied cell presents the smallest entry
    assign o_tail = (r_occ && !i_right_occ) ? r_entry : '0;

endmodule

FILE: sv/sorted_set_insert_remove_min_core.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_remove_min_core
// sorted set of distinct signed values, largest first, held in a chain of
// compare-and-shift cells; insert or remove-smallest per request
// ----------------------------------------------------------------------------
//  channel   | dir | handshake        | payload
//  i_req     | in  | valid / ready    | opcode, value
//  o_res     | out | valid / ready    | smallest, entry_count, status
//
//  a request passes through accept, cell compare, chain update and result
//  the cell compare result must settle before the shift
//  a new request is taken once the previous one has reached the output register
//  the result stage waits while the output register is still full and stalled
//  synchronous active-low reset empties the chain; no clearing pass needed
// ----------------------------------------------------------------------------
`include "sorted_set_insert_remove_min_core_macros.svh"

module sorted_set_insert_remove_min_core import ssirm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssirm_req_if.sink   i_req,
    ssirm_res_if.source o_res
);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD, S_RES} t_state;

    t_state             r_state;
    logic               r_op;
    logic [DATA_W-1:0]  r_value;
    logic [CNT_W-1:0]   r_count;
    t_status            r_status;
    t_status            n_status;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_smallest;
    logic [COUNT_W-1:0] r_out_count;
    t_status            r_out_status;

    t_ctl               w_ctl;
    t_link              w_link [CAPACITY];
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_eq;
    logic [DATA_W-1:0]  w_tail [CAPACITY];
    logic [DATA_W-1:0]  w_smallest;
    logic               w_dup;
    logic               w_full;
    logic               w_load;

    // broadcast control
    assign w_dup       = |w_eq;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_ctl.cmp   = (r_state == S_CMP);
    assign w_ctl.ins   = (r_state == S_UPD) && (r_op == OP_INSERT) && !w_dup && !w_full;
    assign w_ctl.rem   = (r_state == S_UPD) && (r_op == OP_REMOVE) && (r_count != '0);
    assign w_ctl.value = r_value;

    // output register takes a new result when empty or being drained
    assign w_load      = (r_state == S_RES) && (!r_out_valid || o_res.ready);

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link w_left;
        logic  w_right_occ;

        if (g == 0) begin : g_head
            assign w_left.entry = '0;
            assign w_left.occ   = 1'b1;
            assign w_left.gt    = 1'b1;
        end else begin : g_body
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_occ = 1'b0;
        end else begin : g_inner
            assign w_right_occ = w_link[g+1].occ;
        end

        ssirm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_right_occ (w_right_occ),
            .o_link      (w_link[g]),
            .o_eq        (w_eq[g]),
            .o_tail      (w_tail[g])
        );

        assign w_occ[g] = w_link[g].occ;
    end

    // smallest entry: only the last occupied cell contributes
    always_comb begin
        w_smallest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_smallest = w_smallest | w_tail[i];
        end
    end

    // status of the current request, duplicate check first
    always_comb begin
        priority if (r_op == OP_INSERT && w_dup) begin
            n_status = ST_DUP;
        end else if (r_op == OP_INSERT && w_full) begin
            n_status = ST_FULL;
        end else if (r_op == OP_REMOVE && r_count == '0) begin
            n_status = ST_EMPTY;
        end else begin
            n_status = ST_DONE;
        end
    end

    // sequencer, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.opcode;
                        r_value <= i_req.value;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_status <= n_status;
                    if (w_ctl.ins) begin
                        r_count <= r_count + 1'b1;
                    end else if (w_ctl.rem) begin
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (w_load) begin
                        r_out_smallest <= w_smallest;
                        r_out_count    <= COUNT_W'(r_count);
                        r_out_status   <= r_status;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // channel outputs
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.smallest    = r_out_smallest;
    assign o_res.entry_count = r_out_count;
    assign o_res.status      = r_out_status;

    // checks
    `SSIRM_ASSERT_IMP(a_occ_matches_count, i_clk, i_rst_n, 1'b1, $countones(w_occ) == int'(r_count))
    `SSIRM_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1, int'(r_count) <= CAPACITY)
    `SSIRM_ASSERT_NXT(a_insert_grows, i_clk, i_rst_n, w_ctl.ins, r_count == $past(r_count) + 1'b1)
    `SSIRM_ASSERT_NXT(a_refused_keeps, i_clk, i_rst_n, r_state == S_UPD && !w_ctl.ins && !w_ctl.rem, $stable(r_count))

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the sorted set core against a queue-based model of the set kept in
// the bench; directed corner requests, then random fill, drain and mixed
// phases with random idling on both channels, a long result back-pressure
// stretch and a full drain pause
// ----------------------------------------------------------------------------
module tb import ssirm_pkg::*; ;

    localparam int RANDOM_ITEMS   = 1280;
    localparam int CALM_ITEMS     = 150;
    localparam int LONG_HOLD      = 500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [DATA_W-1:0]  smallest;
        logic [COUNT_W-1:0] entry_count;
        t_status            status;
    } t_answer;

    // model of the set, largest value first, plus answers still owed
    class sorted_set_predictor;
        logic signed [DATA_W-1:0] held_vals[$];
        t_answer                  owed_answers[$];
        int unsigned              mismatch_count;

        function void note_request(logic op, logic [DATA_W-1:0] val);
            t_answer                  a;
            int                       pos;
            logic signed [DATA_W-1:0] sval;
            sval     = val;
            a.status = ST_DONE;
            pos      = 0;
            if (op == OP_INSERT) begin
                while (pos < held_vals.size() && held_vals[pos] > sval) pos++;
                if (pos < held_vals.size() && held_vals[pos] == sval) begin
                    a.status = ST_DUP;
                end else if (held_vals.size() >= CAPACITY) begin
                    a.status = ST_FULL;
                end else begin
                    held_vals.insert(pos, sval);
                end
            end else if (held_vals.size() == 0) begin
                a.status = ST_EMPTY;
            end else begin
                void'(held_vals.pop_back());
            end
            a.smallest    = (held_vals.size() != 0) ? held_vals[$] : '0;
            a.entry_count = COUNT_W'(held_vals.size());
            owed_answers.push_back(a);
        endfunction

        function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        endfunction

        function void check_answer(logic [DATA_W-1:0] smallest, logic [COUNT_W-1:0] cnt,
                                   logic [1:0] st);
            t_answer want;
            if (owed_answers.size() == 0) begin
                report("unrequested result", '0, smallest);
                return;
            end
            want = owed_answers.pop_front();
            if (smallest !== want.smallest) report("smallest", want.smallest, smallest);
            if (cnt !== want.entry_count) report("entry_count", want.entry_count, cnt);
            if (st !== want.status) report("status", want.status, st);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm_tail;
    bit   hold_request;
    int   stall_cycles;

    sorted_set_predictor sb;

    ssirm_req_if req_bus ();
    ssirm_res_if res_bus ();

    sorted_set_insert_remove_min_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus.sink),
        .o_res   (res_bus.source)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // accepted request transactions feed the model, result transactions are checked
    always @(posedge clk) begin
        if (rst_n && req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.opcode, req_bus.value);
        if (rst_n && res_bus.valid && res_bus.ready)
            sb.check_answer(res_bus.smallest, res_bus.entry_count, res_bus.status);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $time, stall_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold when asked
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                res_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // offer one request, called at a falling edge, returns at a falling edge
    task automatic offer(input logic op, input logic [DATA_W-1:0] val);
        req_bus.valid  <= 1'b1;
        req_bus.opcode <= op;
        req_bus.value  <= val;
        do @(posedge clk); while (!req_bus.ready);
        @(negedge clk);
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // mix of wide random, small clustered, extreme and already held values
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] extreme_vals[5];
        int                v;
        extreme_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: begin
                v = int'($urandom_range(0, 80)) - 40;
                return v;
            end
            7: return extreme_vals[$urandom_range(0, 4)];
            default: begin
                if (sb.held_vals.size() == 0) return $urandom;
                return sb.held_vals[$urandom_range(0, sb.held_vals.size() - 1)];
            end
        endcase
    endfunction

    initial begin
        int issued;
        int phase_len;
        int insert_weight;
        sb            = new();
        rst_n         = 1'b0;
        calm_tail     = 1'b0;
        hold_request  = 1'b0;
        stall_cycles  = 0;
        req_bus.valid  = 1'b0;
        req_bus.opcode = OP_INSERT;
        req_bus.value  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty remove, extremes, duplicates at both ends, drain to empty
        offer(OP_REMOVE, $urandom);
        offer(OP_INSERT, 32'h0000_0000);
        offer(OP_INSERT, 32'h7fff_ffff);
        offer(OP_INSERT, 32'h8000_0000);
        offer(OP_INSERT, 32'hffff_ffff);
        offer(OP_INSERT, 32'h0000_0001);
        offer(OP_INSERT, 32'h0000_0000);
        offer(OP_INSERT, 32'h8000_0000);
        offer(OP_INSERT, 32'h7fff_ffff);
        offer(OP_INSERT, 32'h8000_0001);
        offer(OP_INSERT, 32'h7fff_fffe);
        repeat (7) offer(OP_REMOVE, $urandom);
        offer(OP_REMOVE, $urandom);
        offer(OP_INSERT, 32'haaaa_aaaa);
        offer(OP_INSERT, 32'h5555_5555);
        offer(OP_REMOVE, 32'hffff_ffff);
        offer(OP_REMOVE, 32'h0000_0000);
        offer(OP_REMOVE, $urandom);

        // random phases: fill, drain or mixed
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 160);
            if (phase_len > RANDOM_ITEMS - issued) phase_len = RANDOM_ITEMS - issued;
            case ($urandom_range(0, 2))
                0:       insert_weight = 7;
                1:       insert_weight = 1;
                default: insert_weight = 4;
            endcase
            repeat (phase_len) begin
                if (issued == 400) begin
                    // stall results for a long stretch while requests keep coming
                    hold_request = 1'b1;
                end
                if (issued == 800) begin
                    // let every outstanding result come back before going on
                    req_bus.valid <= 1'b0;
                    do @(negedge clk); while (sb.owed_answers.size() != 0);
                end
                if (issued >= RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
                if ($urandom_range(0, 7) < insert_weight)
                    offer(OP_INSERT, pick_value());
                else
                    offer(OP_REMOVE, $urandom);
                issued++;
            end
        end
        req_bus.valid <= 1'b0;

        // wait for outstanding results, then idle before reporting
        while (sb.owed_answers.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        sb.mismatch_count += sb.owed_answers.size();
        if (sb.mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
